[design/smpq_pkg.sv]
// Shared types and constants for the sorted max priority queue.
// Used by smpq_cell and sorted_max_priority_queue; depends on nothing else.
package smpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 7;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] value_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [1:0]               status;
        logic [OUT_CNT_W-1:0]     entry_count;
    } out_beat_t;

    // Broadcast to every cell of the chain in each cycle.
    typedef struct packed {
        logic                     insert;
        logic                     remove;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

[design/smpq_cell.sv]
// One storage cell of the sorted chain: holds a single value and trades it
// with its neighbours. Depends on smpq_pkg.
module smpq_cell (
    input  logic                             clk,
    input  smpq_pkg::cell_ctrl_t             ctrl,
    input  logic                             occupied,
    input  logic                             prev_keep,
    input  logic signed [smpq_pkg::DATA_W-1:0] prev_value,
    input  logic signed [smpq_pkg::DATA_W-1:0] next_value,
    output logic                             keep,
    output logic signed [smpq_pkg::DATA_W-1:0] value
);
    import smpq_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    // A cell keeps its value on insert when it holds an entry at least as
    // large as the new one, so equal values stay ahead of the newcomer.
    assign keep  = occupied && (value_reg >= ctrl.value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (!keep)
            begin
                value_next = prev_keep ? ctrl.value : prev_value;
            end
        end
        else if (ctrl.remove)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

[design/sorted_max_priority_queue.sv]
// Top level of the sorted max priority queue: a chain of smpq_cell stages,
// the fill counter and the result register. Depends on smpq_pkg and smpq_cell.
//
// Usage: each input beat on in_data carries a command. An enqueue places
// value_in behind every stored entry that is greater than or equal to it; a
// dequeue removes and returns the largest entry. Every input beat yields
// exactly one output beat on out_data with the removed value (zero unless a
// dequeue succeeded), a status code and the number of entries afterwards.
// The result appears on out_data in the cycle after the input beat is taken.
// While out_ready holds, throughput is one beat per cycle, because every
// cell compares against the new value at the same time and the whole chain
// shifts at once. If the receiver stalls, the result waits in
// the output register and in_ready falls until that beat is taken, so no
// result is ever lost or overwritten. A dequeue on an empty queue reports
// the empty status; an enqueue into a full queue is dropped with the full
// status. Reset empties the queue and clears the output valid; the cell
// contents are not cleared, since no cell is read beyond the fill count.
module sorted_max_priority_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  smpq_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output smpq_pkg::out_beat_t out_data
);
    import smpq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_beat_t        out_data_reg;
    out_beat_t        out_data_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    cell_ctrl_t       ctrl;

    logic                     cell_keep  [CAPACITY];
    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]      occupied;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // The cells only move when the command will succeed.
    always_comb
    begin
        ctrl.insert = accept && (in_data.command == CMD_ENQ) && !is_full;
        ctrl.remove = accept && (in_data.command == CMD_DEQ) && !is_empty;
        ctrl.value  = in_data.value_in;
    end

    // The chain itself: each cell looks only at its neighbours.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign occupied[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            smpq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occupied[i]),
                .prev_keep  (1'b1),
                .prev_value ('0),
                .next_value (cell_value[i+1]),
                .keep       (cell_keep[i]),
                .value      (cell_value[i])
            );
        end
        else if (i == CAPACITY - 1)
        begin : g_tail
            smpq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occupied[i]),
                .prev_keep  (cell_keep[i-1]),
                .prev_value (cell_value[i-1]),
                .next_value (cell_value[i]),
                .keep       (cell_keep[i]),
                .value      (cell_value[i])
            );
        end
        else
        begin : g_mid
            smpq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occupied[i]),
                .prev_keep  (cell_keep[i-1]),
                .prev_value (cell_value[i-1]),
                .next_value (cell_value[i+1]),
                .keep       (cell_keep[i]),
                .value      (cell_value[i])
            );
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next          = 1'b1;
            out_data_next.value_out = '0;
            out_data_next.status    = ST_OK;
            if (in_data.command == CMD_DEQ)
            begin
                if (is_empty)
                begin
                    out_data_next.status = ST_EMPTY;
                end
                else
                begin
                    out_data_next.value_out = cell_value[0];
                    count_next              = count_reg - CNT_W'(1);
                end
            end
            else
            begin
                if (is_full)
                begin
                    out_data_next.status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            out_data_next.entry_count = OUT_CNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The fill count never runs past the capacity of the chain.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // Every accepted beat leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat produced no result");

    // An error result never carries a value.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.status != ST_OK)) |->
        (out_data_reg.value_out == '0))
        else $error("error result with non-zero value");

    // A successful enqueue moves the count up by exactly one.
    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("enqueue did not advance the count");

endmodule
